/* design/hky_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the HKY85 transition probability block.
// Used by every module of the block; depends on nothing.
package hky_pkg;

  localparam int CfgIndexW = 3;
  localparam int CfgDataW  = 16;

  localparam logic [CfgIndexW-1:0] REG_PI_A  = 3'd0;
  localparam logic [CfgIndexW-1:0] REG_PI_C  = 3'd1;
  localparam logic [CfgIndexW-1:0] REG_PI_G  = 3'd2;
  localparam logic [CfgIndexW-1:0] REG_PI_T  = 3'd3;
  localparam logic [CfgIndexW-1:0] REG_KAPPA = 3'd4;

  localparam logic [15:0] PI_RESET    = 16'd16384;
  localparam logic [15:0] KAPPA_RESET = 16'd256;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [16:0] PROB_ONE = 17'd65536;

  typedef struct packed {
    logic [15:0] pi_a;
    logic [15:0] pi_c;
    logic [15:0] pi_g;
    logic [15:0] pi_t;
    logic [15:0] kappa;
  } cfg_t;

  typedef struct packed {
    logic [23:0] t;
    logic        inv;
  } item_t;

  typedef struct packed {
    logic        inv;
    logic [16:0] p00;
    logic [16:0] p02;
    logic [16:0] p11;
    logic [16:0] p13;
    logic [16:0] p20;
    logic [16:0] p22;
    logic [16:0] p31;
    logic [16:0] p33;
    logic [16:0] oa;
    logic [16:0] oc;
    logic [16:0] og;
    logic [16:0] ot;
  } mat_t;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic         done;
    logic [127:0] p;
  } mul_rsp_t;

  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [63:0] den;
    logic [6:0]  steps;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] q;
  } div_rsp_t;

endpackage

/* design/hky_front.sv */
`timescale 1ns / 1ps
// Front end: accepts branch lengths, flags degenerate frequencies, queues words.
// Depends on hky_pkg.
module hky_front
  import hky_pkg::*;
#(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [23:0] branch_length,
  output logic        q_valid,
  output item_t       q_item,
  input  logic        q_pop
);

  localparam int AddrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CountW = $clog2(QueueDepth + 1);

  item_t               mem [QueueDepth];
  logic [AddrW-1:0]    head;
  logic [AddrW-1:0]    tail;
  logic [CountW-1:0]   count;
  logic                push;
  logic [16:0]         sum_r;
  logic [16:0]         sum_y;

  assign sum_r    = {1'b0, cfg.pi_a} + {1'b0, cfg.pi_g};
  assign sum_y    = {1'b0, cfg.pi_c} + {1'b0, cfg.pi_t};
  assign in_stall = (count == CountW'(QueueDepth));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign q_item   = mem[head];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= '{t: branch_length, inv: (sum_r == '0) || (sum_y == '0)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= (tail == AddrW'(QueueDepth - 1)) ? '0 : tail + 1'b1;
      end
      if (q_pop && q_valid) begin
        head <= (head == AddrW'(QueueDepth - 1)) ? '0 : head + 1'b1;
      end
      if (push && !(q_pop && q_valid)) begin
        count <= count + 1'b1;
      end else if (!push && q_pop && q_valid) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* design/hky_mul.sv */
`timescale 1ns / 1ps
// Shared 64 x 64 multiplier, one 16-bit digit of the second operand a cycle.
// Depends on hky_pkg.
module hky_mul
  import hky_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  logic [63:0]  a;
  logic [63:0]  b;
  logic [127:0] acc;
  logic [2:0]   cnt;
  logic [79:0]  part;
  logic         done;

  assign part = a * b[63:48];
  assign rsp  = '{done: done, p: acc};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        a   <= req.a;
        b   <= req.b;
        acc <= '0;
        cnt <= 3'd4;
      end else if (cnt != '0) begin
        acc  <= {acc[111:0], 16'd0} + {48'd0, part};
        b    <= {b[47:0], 16'd0};
        cnt  <= cnt - 1'b1;
        done <= (cnt == 3'd1);
      end
    end
  end

endmodule

/* design/hky_div.sv */
`timescale 1ns / 1ps
// Shared restoring divider, one quotient bit a cycle over a chosen dividend width.
// Depends on hky_pkg.
module hky_div
  import hky_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [63:0] num;
  logic [63:0] den;
  logic [63:0] rem;
  logic [63:0] quo;
  logic [6:0]  cnt;
  logic [64:0] rem_sh;
  logic        fits;
  logic [6:0]  sh;
  logic        done;

  assign sh     = 7'd64 - req.steps;
  assign rem_sh = {rem, num[63]};
  assign fits   = (rem_sh >= {1'b0, den});
  assign rsp    = '{done: done, q: quo};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        num <= req.num << sh;
        den <= req.den;
        rem <= '0;
        quo <= '0;
        cnt <= req.steps;
      end else if (cnt != '0) begin
        rem  <= fits ? 64'(rem_sh - {1'b0, den}) : rem_sh[63:0];
        quo  <= {quo[62:0], fits};
        num  <= {num[62:0], 1'b0};
        cnt  <= cnt - 1'b1;
        done <= (cnt == 7'd1);
      end
    end
  end

endmodule

/* design/hky_core.sv */
`timescale 1ns / 1ps
// Back end sequencer: forms beta*t, the three decays and the twelve distinct entries.
// Depends on hky_pkg; drives the shared hky_mul and hky_div units.
module hky_core
  import hky_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     q_valid,
  input  item_t    q_item,
  output logic     q_pop,
  output mul_req_t mul_req,
  input  mul_rsp_t mul_rsp,
  output div_req_t div_req,
  input  div_rsp_t div_rsp,
  output logic     mat_valid,
  input  logic     mat_ready,
  output mat_t     mat
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_PPY    = 5'd1;
  localparam logic [4:0] S_PAG    = 5'd2;
  localparam logic [4:0] S_PCT    = 5'd3;
  localparam logic [4:0] S_D40    = 5'd4;
  localparam logic [4:0] S_X16    = 5'd5;
  localparam logic [4:0] S_RATE   = 5'd6;
  localparam logic [4:0] S_YMUL   = 5'd7;
  localparam logic [4:0] S_TMUL   = 5'd8;
  localparam logic [4:0] S_TDIV   = 5'd9;
  localparam logic [4:0] S_SQINIT = 5'd10;
  localparam logic [4:0] S_SQ     = 5'd11;
  localparam logic [4:0] S_STORE  = 5'd12;
  localparam logic [4:0] S_BASER  = 5'd13;
  localparam logic [4:0] S_BASEY  = 5'd14;
  localparam logic [4:0] S_HMUL   = 5'd15;
  localparam logic [4:0] S_GMUL   = 5'd16;
  localparam logic [4:0] S_EDIV   = 5'd17;
  localparam logic [4:0] S_OMUL   = 5'd18;
  localparam logic [4:0] S_DONE   = 5'd19;

  localparam logic [24:0] ONE24 = 25'd16777216;
  localparam logic [30:0] ONE30 = 31'd1073741824;

  logic [4:0]         state;
  logic               busy;
  logic               unit_done;
  logic [16:0]        pr;
  logic [16:0]        py;
  logic [23:0]        t;
  logic               inv;
  logic [33:0]        ppy;
  logic [32:0]        s1;
  logic [50:0]        d40;
  logic [63:0]        x16;
  logic [1:0]         dsel;
  logic signed [35:0] r;
  logic [24:0]        dec;
  logic [25:0]        u30;
  logic [30:0]        term;
  logic [26:0]        tmp;
  logic signed [33:0] sum;
  logic [2:0]         k;
  logic [30:0]        e;
  logic [3:0]         sq;
  logic [24:0]        a24;
  logic [24:0]        br24;
  logic [24:0]        by24;
  logic [42:0]        base_r;
  logic [42:0]        base_y;
  logic [58:0]        hv;
  logic [36:0]        ediv;
  logic [2:0]         j;
  logic [1:0]         o;
  logic [16:0]        pd [8];
  logic [16:0]        od [4];

  logic [15:0]        hf;
  logic [42:0]        hb;
  logic [15:0]        gf;
  logic [24:0]        gd;
  logic [16:0]        pden;
  logic               plus;
  logic [15:0]        of;
  logic [16:0]        rp;
  logic [32:0]        recip;
  logic [24:0]        one_m_a;
  logic [127:0]       mp;
  logic signed [60:0] gnum;
  logic [60:0]        rnd;
  logic [60:0]        sqr;
  logic [30:0]        e2;
  logic [31:0]        fr;
  logic [49:0]        dsum;
  logic [41:0]        ornd;
  logic [30:0]        tq;
  logic               need_mul;
  logic               need_div;
  logic [63:0]        op_a;
  logic [63:0]        op_b;
  logic [63:0]        dv_num;
  logic [63:0]        dv_den;
  logic [6:0]         dv_steps;
  logic               mul_start;
  logic [63:0]        mul_a;
  logic [63:0]        mul_b;
  logic               div_start;
  logic [63:0]        div_num;
  logic [63:0]        div_den;
  logic [6:0]         div_steps;

  assign pr        = {1'b0, cfg.pi_a} + {1'b0, cfg.pi_g};
  assign py        = {1'b0, cfg.pi_c} + {1'b0, cfg.pi_t};
  assign unit_done = mul_rsp.done || div_rsp.done;
  assign mp        = mul_rsp.p;
  assign tq        = {4'd0, mp[58:32]};

  assign mul_req = '{start: mul_start, a: mul_a, b: mul_b};
  assign div_req = '{start: div_start, num: div_num, den: div_den, steps: div_steps};

  assign hf      = j[1] ? (j[0] ? cfg.pi_t : cfg.pi_c) : (j[0] ? cfg.pi_g : cfg.pi_a);
  assign hb      = j[1] ? base_y : base_r;
  assign gf      = j[2] ? (j[1] ? cfg.pi_c : cfg.pi_a) : (j[1] ? cfg.pi_t : cfg.pi_g);
  assign gd      = j[1] ? by24 : br24;
  assign pden    = j[1] ? py : pr;
  assign plus    = ~(j[0] ^ j[2]);
  assign one_m_a = ONE24 - a24;

  // Each Taylor term is divided by k through a multiply by ceil(2^32 / k).
  always_comb begin
    case (o)
      2'd0:    of = cfg.pi_a;
      2'd1:    of = cfg.pi_c;
      2'd2:    of = cfg.pi_g;
      default: of = cfg.pi_t;
    endcase
    case (dsel)
      2'd1:    rp = pr;
      2'd2:    rp = py;
      default: rp = '0;
    endcase
    case (k)
      3'd1:    recip = 33'd4294967296;
      3'd2:    recip = 33'd2147483648;
      3'd3:    recip = 33'd1431655766;
      3'd4:    recip = 33'd1073741824;
      3'd5:    recip = 33'd858993460;
      default: recip = 33'd715827883;
    endcase
  end

  assign gnum = plus ? $signed({2'b00, hv}) + $signed({4'b0000, mp[40:0], 16'd0})
                     : $signed({2'b00, hv}) - $signed({4'b0000, mp[40:0], 16'd0});
  assign rnd  = {1'b0, gnum[59:0]} + {21'd0, pden, 23'd0};
  assign sqr  = mp[60:0] + 61'd536870912;
  assign e2   = sqr[60:30];
  assign fr   = {1'b0, e2} + 32'd32;
  assign dsum = {8'd0, ppy, 8'd0} + {1'b0, mp[48:0]};
  assign ornd = {1'b0, mp[40:0]} + 42'd8388608;

  always_comb begin
    need_mul = 1'b0;
    need_div = 1'b0;
    op_a     = '0;
    op_b     = '0;
    dv_num   = '0;
    dv_den   = '0;
    dv_steps = 7'd64;
    case (state)
      S_PPY: begin
        need_mul = 1'b1; op_a = 64'(pr); op_b = 64'(py);
      end
      S_PAG: begin
        need_mul = 1'b1; op_a = 64'(cfg.pi_a); op_b = 64'(cfg.pi_g);
      end
      S_PCT: begin
        need_mul = 1'b1; op_a = 64'(cfg.pi_c); op_b = 64'(cfg.pi_t);
      end
      S_D40: begin
        need_mul = 1'b1; op_a = 64'(cfg.kappa); op_b = 64'(s1);
      end
      S_X16: begin
        need_div = 1'b1; dv_num = {t, 40'd0}; dv_den = 64'(d40); dv_steps = 7'd64;
      end
      S_RATE: begin
        need_mul = 1'b1; op_a = 64'(rp); op_b = 64'(cfg.kappa);
      end
      S_YMUL: begin
        need_mul = (r > 36'sd0); op_a = x16; op_b = 64'(r[33:0]);
      end
      S_TMUL: begin
        need_mul = 1'b1; op_a = 64'(term); op_b = 64'(u30);
      end
      S_TDIV: begin
        need_mul = 1'b1; op_a = 64'(tmp); op_b = 64'(recip);
      end
      S_SQ: begin
        need_mul = 1'b1; op_a = 64'(e); op_b = 64'(e);
      end
      S_BASER: begin
        need_mul = 1'b1; op_a = 64'(py); op_b = 64'(a24);
      end
      S_BASEY: begin
        need_mul = 1'b1; op_a = 64'(pr); op_b = 64'(a24);
      end
      S_HMUL: begin
        need_mul = 1'b1; op_a = 64'(hf); op_b = 64'(hb);
      end
      S_GMUL: begin
        need_mul = 1'b1; op_a = 64'(gf); op_b = 64'(gd);
      end
      S_EDIV: begin
        need_div = 1'b1; dv_num = 64'(ediv); dv_den = 64'(pden); dv_steps = 7'd40;
      end
      S_OMUL: begin
        need_mul = 1'b1; op_a = 64'(of); op_b = 64'(one_m_a);
      end
      default: begin
        need_mul = 1'b0;
      end
    endcase
  end

  assign q_pop     = (state == S_IDLE) && q_valid;
  assign mat_valid = (state == S_DONE) && mat_ready;

  assign mat.inv = inv;
  assign mat.p00 = pd[0];
  assign mat.p02 = pd[1];
  assign mat.p11 = pd[2];
  assign mat.p13 = pd[3];
  assign mat.p20 = pd[4];
  assign mat.p22 = pd[5];
  assign mat.p31 = pd[6];
  assign mat.p33 = pd[7];
  assign mat.oa  = od[0];
  assign mat.oc  = od[1];
  assign mat.og  = od[2];
  assign mat.ot  = od[3];

  always_ff @(posedge clk) begin
    if (!busy && (need_mul || need_div)) begin
      mul_a     <= op_a;
      mul_b     <= op_b;
      div_num   <= dv_num;
      div_den   <= dv_den;
      div_steps <= dv_steps;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      busy      <= 1'b0;
      mul_start <= 1'b0;
      div_start <= 1'b0;
    end else begin
      mul_start <= 1'b0;
      div_start <= 1'b0;
      if (!busy && (need_mul || need_div)) begin
        busy      <= 1'b1;
        mul_start <= need_mul;
        div_start <= need_div;
      end
      if (busy && unit_done) begin
        busy <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            t     <= q_item.t;
            inv   <= q_item.inv;
            state <= q_item.inv ? S_DONE : S_PPY;
          end
        end
        S_PPY: begin
          if (busy && unit_done) begin
            ppy   <= mp[33:0];
            state <= S_PAG;
          end
        end
        S_PAG: begin
          if (busy && unit_done) begin
            s1    <= mp[32:0];
            state <= S_PCT;
          end
        end
        S_PCT: begin
          if (busy && unit_done) begin
            s1    <= s1 + mp[32:0];
            state <= S_D40;
          end
        end
        S_D40: begin
          if (busy && unit_done) begin
            d40   <= {dsum, 1'b0};
            state <= S_X16;
          end
        end
        S_X16: begin
          if (busy && unit_done) begin
            x16   <= div_rsp.q;
            dsel  <= 2'd0;
            state <= S_RATE;
          end
        end
        S_RATE: begin
          if (busy && unit_done) begin
            r <= $signed({11'd0, ONE24}) + $signed({2'b00, mp[33:0]})
                 - $signed({11'd0, rp, 8'd0});
            state <= S_YMUL;
          end
        end
        S_YMUL: begin
          if (!busy && !(r > 36'sd0)) begin
            dec   <= ONE24;
            state <= S_STORE;
          end else if (busy && unit_done) begin
            if (mp[127:46] != '0) begin
              dec   <= '0;
              state <= S_STORE;
            end else begin
              u30   <= {mp[45:24], 4'd0};
              term  <= ONE30;
              sum   <= $signed({3'b000, ONE30});
              k     <= 3'd1;
              state <= S_TMUL;
            end
          end
        end
        S_TMUL: begin
          if (busy && unit_done) begin
            tmp   <= mp[56:30];
            state <= S_TDIV;
          end
        end
        S_TDIV: begin
          if (busy && unit_done) begin
            term <= tq;
            if (k[0]) begin
              sum <= sum - $signed({3'b000, tq});
            end else begin
              sum <= sum + $signed({3'b000, tq});
            end
            if (k == 3'd6) begin
              state <= S_SQINIT;
            end else begin
              k     <= k + 1'b1;
              state <= S_TMUL;
            end
          end
        end
        S_SQINIT: begin
          if (sum < 34'sd0) begin
            e <= '0;
          end else if (sum > $signed({3'b000, ONE30})) begin
            e <= ONE30;
          end else begin
            e <= sum[30:0];
          end
          sq    <= '0;
          state <= S_SQ;
        end
        S_SQ: begin
          if (busy && unit_done) begin
            e <= e2;
            if (sq == 4'd9) begin
              dec   <= (fr[31:6] > 26'(ONE24)) ? ONE24 : fr[30:6];
              state <= S_STORE;
            end else begin
              sq <= sq + 1'b1;
            end
          end
        end
        S_STORE: begin
          case (dsel)
            2'd0:    a24  <= dec;
            2'd1:    br24 <= dec;
            default: by24 <= dec;
          endcase
          if (dsel == 2'd2) begin
            state <= S_BASER;
          end else begin
            dsel  <= dsel + 1'b1;
            state <= S_RATE;
          end
        end
        S_BASER: begin
          if (busy && unit_done) begin
            base_r <= {2'b00, pr, 24'd0} + mp[42:0];
            state  <= S_BASEY;
          end
        end
        S_BASEY: begin
          if (busy && unit_done) begin
            base_y <= {2'b00, py, 24'd0} + mp[42:0];
            j      <= '0;
            state  <= S_HMUL;
          end
        end
        S_HMUL: begin
          if (busy && unit_done) begin
            hv    <= mp[58:0];
            state <= S_GMUL;
          end
        end
        S_GMUL: begin
          if (busy && unit_done) begin
            if (gnum <= 61'sd0) begin
              pd[j] <= '0;
              if (j == 3'd7) begin
                o     <= '0;
                state <= S_OMUL;
              end else begin
                j     <= j + 1'b1;
                state <= S_HMUL;
              end
            end else begin
              ediv  <= rnd[60:24];
              state <= S_EDIV;
            end
          end
        end
        S_EDIV: begin
          if (busy && unit_done) begin
            pd[j] <= (div_rsp.q > 64'(PROB_ONE)) ? PROB_ONE : div_rsp.q[16:0];
            if (j == 3'd7) begin
              o     <= '0;
              state <= S_OMUL;
            end else begin
              j     <= j + 1'b1;
              state <= S_HMUL;
            end
          end
        end
        S_OMUL: begin
          if (busy && unit_done) begin
            od[o] <= (ornd[41:24] > 18'(PROB_ONE)) ? PROB_ONE : ornd[40:24];
            if (o == 2'd3) begin
              state <= S_DONE;
            end else begin
              o <= o + 1'b1;
            end
          end
        end
        S_DONE: begin
          if (mat_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* design/hky_emit.sv */
`timescale 1ns / 1ps
// Result stage: holds one finished matrix and sends it as four row words.
// Depends on hky_pkg.
module hky_emit
  import hky_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        mat_valid,
  output logic        mat_ready,
  input  mat_t        mat,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  from_base,
  output logic [16:0] prob_to_a,
  output logic [16:0] prob_to_c,
  output logic [16:0] prob_to_g,
  output logic [16:0] prob_to_t,
  output logic        invalid,
  output logic        last_row
);

  mat_t       m;
  logic       valid;
  logic [1:0] row;

  assign mat_ready = !valid;
  assign out_valid = valid;
  assign from_base = row;
  assign last_row  = (row == 2'd3);
  assign invalid   = m.inv;

  always_comb begin
    case (row)
      2'd0: begin
        prob_to_a = m.p00; prob_to_c = m.oc;  prob_to_g = m.p02; prob_to_t = m.ot;
      end
      2'd1: begin
        prob_to_a = m.oa;  prob_to_c = m.p11; prob_to_g = m.og;  prob_to_t = m.p13;
      end
      2'd2: begin
        prob_to_a = m.p20; prob_to_c = m.oc;  prob_to_g = m.p22; prob_to_t = m.ot;
      end
      default: begin
        prob_to_a = m.oa;  prob_to_c = m.p31; prob_to_g = m.og;  prob_to_t = m.p33;
      end
    endcase
    if (m.inv) begin
      prob_to_a = '0;
      prob_to_c = '0;
      prob_to_g = '0;
      prob_to_t = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (mat_valid && !valid) begin
      m <= mat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      row   <= '0;
    end else if (mat_valid && !valid) begin
      valid <= 1'b1;
      row   <= '0;
    end else if (valid && !out_stall) begin
      row <= row + 1'b1;
      if (row == 2'd3) begin
        valid <= 1'b0;
      end
    end
  end

endmodule

/* design/hky_transition_probability_top.sv */
`timescale 1ns / 1ps
// HKY85 transition probability matrix: one branch length in, four row words out.
// The back end holds one branch length at a time, so throughput is one per back-end pass,
// set by the shared one-bit-per-cycle divider and the digit-serial multiplier that hky_core drives.
// Input words queue while the back end works; a finished matrix waits in hky_emit.
// Synchronous reset empties the queue and sets pi_a..pi_t to 0.25 and kappa to 1.0.
module hky_transition_probability_top
  import hky_pkg::*;
#(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [23:0]          branch_length,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           from_base,
  output logic [16:0]          prob_to_a,
  output logic [16:0]          prob_to_c,
  output logic [16:0]          prob_to_g,
  output logic [16:0]          prob_to_t,
  output logic                 invalid,
  output logic                 last_row
);

  cfg_t     cfg;
  logic     q_valid;
  item_t    q_item;
  logic     q_pop;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;
  logic     mat_valid;
  logic     mat_ready;
  mat_t     mat;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pi_a  <= PI_RESET;
      cfg.pi_c  <= PI_RESET;
      cfg.pi_g  <= PI_RESET;
      cfg.pi_t  <= PI_RESET;
      cfg.kappa <= KAPPA_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PI_A:  cfg.pi_a  <= cfg_data;
        REG_PI_C:  cfg.pi_c  <= cfg_data;
        REG_PI_G:  cfg.pi_g  <= cfg_data;
        REG_PI_T:  cfg.pi_t  <= cfg_data;
        REG_KAPPA: cfg.kappa <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  hky_front #(
    .QueueDepth(QueueDepth)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .branch_length(branch_length),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  hky_mul u_mul (
    .clk(clk),
    .rst(rst),
    .req(mul_req),
    .rsp(mul_rsp)
  );

  hky_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  hky_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .mul_req  (mul_req),
    .mul_rsp  (mul_rsp),
    .div_req  (div_req),
    .div_rsp  (div_rsp),
    .mat_valid(mat_valid),
    .mat_ready(mat_ready),
    .mat      (mat)
  );

  hky_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .mat_valid(mat_valid),
    .mat_ready(mat_ready),
    .mat      (mat),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .from_base(from_base),
    .prob_to_a(prob_to_a),
    .prob_to_c(prob_to_c),
    .prob_to_g(prob_to_g),
    .prob_to_t(prob_to_t),
    .invalid  (invalid),
    .last_row (last_row)
  );

endmodule

/* design/hky_checker.sv */
`timescale 1ns / 1ps
// Port-level checks on the row words of the transition probability block.
// Bound to hky_transition_probability_top; depends on nothing else.
module hky_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  from_base,
  input logic [16:0] prob_to_a,
  input logic [16:0] prob_to_c,
  input logic [16:0] prob_to_g,
  input logic [16:0] prob_to_t,
  input logic        invalid,
  input logic        last_row
);

  a_last_marks_fourth: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_row == (from_base == 2'd3)))
    else $error("Last row flag does not match the row index.");

  a_rows_in_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_row |=>
      out_valid && (from_base == $past(from_base) + 2'd1))
    else $error("Rows of one matrix are not sent back to back in order.");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && invalid |->
      (prob_to_a == '0) && (prob_to_c == '0) && (prob_to_g == '0) && (prob_to_t == '0))
    else $error("Invalid matrix carries nonzero probabilities.");

  a_prob_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (prob_to_a <= 17'd65536) && (prob_to_c <= 17'd65536) &&
                  (prob_to_g <= 17'd65536) && (prob_to_t <= 17'd65536))
    else $error("Probability above one.");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("Output word dropped while stalled.");

endmodule

bind hky_transition_probability_top hky_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .from_base(from_base),
  .prob_to_a(prob_to_a),
  .prob_to_c(prob_to_c),
  .prob_to_g(prob_to_g),
  .prob_to_t(prob_to_t),
  .invalid  (invalid),
  .last_row (last_row)
);
